/* hw/rtl/mclp_pkg.sv */
// ----------------------------------------------------------------------------
// mclp_pkg
// Shared types and constants for the multi-click LED pattern controller.
// ----------------------------------------------------------------------------
`default_nettype none

package mclp_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned LED_OUT_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LIMIT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_ROTATE_UP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_ROTATE_DOWN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BINARY_COUNT = 2'd3;

  localparam logic [CFG_W-1:0] RST_QUIET_LIMIT       = 16'd500;
  localparam logic [CFG_W-1:0] RST_RATE_ROTATE_UP    = 16'd50;
  localparam logic [CFG_W-1:0] RST_RATE_ROTATE_DOWN  = 16'd140;
  localparam logic [CFG_W-1:0] RST_RATE_BINARY_COUNT = 16'd50;

  localparam logic [MODE_W-1:0] MODE_ROTATE_UP    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROTATE_DOWN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BINARY_COUNT = 2'd2;

  localparam logic [7:0] START_ROTATE_UP   = 8'h66;
  localparam logic [7:0] START_ROTATE_DOWN = 8'h30;

  typedef struct packed {
    logic              commit;
    logic [MODE_W-1:0] mode;
  } commit_t;

endpackage

`default_nettype wire

/* hw/rtl/mclp_click.sv */
// ----------------------------------------------------------------------------
// mclp_click
// Button click counter: edge detect, quiet timer and mode commit decision.
// ----------------------------------------------------------------------------
`default_nettype none

module mclp_click
  import mclp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic             button,
  input  wire logic [CFG_W-1:0] quiet_limit,
  output commit_t               commit
);

  logic             prev_button_r, prev_button_nxt;
  logic [CFG_W-1:0] ticks_r, ticks_nxt;
  logic             pending_r, pending_nxt;
  logic [1:0]       residue_r, residue_nxt;

  logic             rising;
  logic [CFG_W:0]   ticks_inc;
  logic             do_commit;
  logic [1:0]       residue_inc;
  logic [1:0]       commit_mode;

  always_comb begin
    rising    = button && !prev_button_r;
    ticks_inc = {1'b0, ticks_r} + {{CFG_W{1'b0}}, 1'b1};
    do_commit = !rising && pending_r && (ticks_r >= quiet_limit);

    case (residue_r)
      2'd0:    residue_inc = 2'd1;
      2'd1:    residue_inc = 2'd2;
      default: residue_inc = 2'd0;
    endcase

    // (residue + 2) mod 3 gives the mode for the collected clicks
    case (residue_r)
      2'd0:    commit_mode = MODE_BINARY_COUNT;
      2'd1:    commit_mode = MODE_ROTATE_UP;
      default: commit_mode = MODE_ROTATE_DOWN;
    endcase

    prev_button_nxt = button;
    pending_nxt     = pending_r;
    residue_nxt     = residue_r;
    if (rising) begin
      pending_nxt = 1'b1;
      residue_nxt = residue_inc;
      ticks_nxt   = (quiet_limit == '0) ? '0 : CFG_W'(1);
    end else begin
      if (do_commit) begin
        pending_nxt = 1'b0;
        residue_nxt = 2'd0;
      end
      ticks_nxt = (ticks_inc > {1'b0, quiet_limit}) ? quiet_limit
                                                    : ticks_inc[CFG_W-1:0];
    end

    commit.commit = do_commit;
    commit.mode   = commit_mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_button_r <= 1'b1;
      ticks_r       <= '0;
      pending_r     <= 1'b0;
      residue_r     <= 2'd0;
    end else if (step) begin
      prev_button_r <= prev_button_nxt;
      ticks_r       <= ticks_nxt;
      pending_r     <= pending_nxt;
      residue_r     <= residue_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/multi_click_led_pattern_controller.sv */
// ----------------------------------------------------------------------------
// multi_click_led_pattern_controller
// Button-driven LED pattern generator with multi-click mode selection.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on in_* is one 1 ms tick carrying the sampled button
//   level. Every input word yields exactly one output word on out_* holding
//   the LED pattern and active mode after that tick.
//   Each word passes through the input register, then the pattern and mode
//   registers that drive out_*. One word per cycle is sustained while
//   out_stall is low; the input and state registers each hold one word.
//   A stalled output holds its word and state; the input register keeps
//   filling, and in_stall rises only once it is also occupied.
//   Reset (rst_n low, synchronous) loads mode 0, pattern 0x66, countdown 0
//   and the register defaults (timeout 500, rates 50/140/50).
//   The cfg_* port writes one 16-bit register per enabled cycle; write only
//   while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_click_led_pattern_controller
  import mclp_pkg::*;
#(
  parameter int unsigned LED_COUNT = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic                 in_button_level,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [LED_OUT_W-1:0] out_led_pattern,
  output      logic [MODE_W-1:0]    out_active_mode,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [LED_COUNT-1:0] START_UP   = LED_COUNT'(START_ROTATE_UP);
  localparam logic [LED_COUNT-1:0] START_DOWN = LED_COUNT'(START_ROTATE_DOWN);

  logic [CFG_W-1:0] quiet_limit_r;
  logic [CFG_W-1:0] rate_up_r;
  logic [CFG_W-1:0] rate_down_r;
  logic [CFG_W-1:0] rate_count_r;

  logic                 in_valid_r;
  logic                 in_button_r;
  logic                 out_valid_r;
  logic [LED_COUNT-1:0] pattern_r, pattern_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [CFG_W-1:0]     countdown_r, countdown_nxt;
  logic [LED_COUNT-1:0] counter_r, counter_nxt;

  logic                 advance;
  logic                 step;
  commit_t              commit;
  logic [CFG_W-1:0]     mode_rate;
  logic [LED_COUNT-1:0] pattern_base;
  logic [CFG_W-1:0]     countdown_base;
  logic [LED_COUNT-1:0] counter_base;
  logic [LED_COUNT-1:0] counter_inc;
  logic [LED_COUNT+LED_OUT_W-1:0] pattern_ext;

  assign advance  = !out_valid_r || !out_stall;
  assign step     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_limit_r <= RST_QUIET_LIMIT;
      rate_up_r     <= RST_RATE_ROTATE_UP;
      rate_down_r   <= RST_RATE_ROTATE_DOWN;
      rate_count_r  <= RST_RATE_BINARY_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUIET_LIMIT:       quiet_limit_r <= cfg_data;
        CFG_RATE_ROTATE_UP:    rate_up_r     <= cfg_data;
        CFG_RATE_ROTATE_DOWN:  rate_down_r   <= cfg_data;
        CFG_RATE_BINARY_COUNT: rate_count_r  <= cfg_data;
        default:               ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_button_r <= in_button_level;
    end
  end

  mclp_click u_click (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .button      (in_button_r),
    .quiet_limit (quiet_limit_r),
    .commit      (commit)
  );

  always_comb begin
    mode_nxt       = commit.commit ? commit.mode : mode_r;
    countdown_base = countdown_r;
    pattern_base   = pattern_r;
    counter_base   = counter_r;

    case (mode_nxt)
      MODE_ROTATE_UP:   mode_rate = rate_up_r;
      MODE_ROTATE_DOWN: mode_rate = rate_down_r;
      default:          mode_rate = rate_count_r;
    endcase

    if (commit.commit) begin
      countdown_base = mode_rate;
      counter_base   = '0;
      case (commit.mode)
        MODE_ROTATE_UP:   pattern_base = START_UP;
        MODE_ROTATE_DOWN: pattern_base = START_DOWN;
        default:          pattern_base = '0;
      endcase
    end

    counter_inc   = counter_base + LED_COUNT'(1);
    pattern_nxt   = pattern_base;
    counter_nxt   = counter_base;
    countdown_nxt = countdown_base;
    if (countdown_base == '0) begin
      case (mode_nxt)
        MODE_ROTATE_UP:
          pattern_nxt = {pattern_base[LED_COUNT-2:0], pattern_base[LED_COUNT-1]};
        MODE_ROTATE_DOWN:
          pattern_nxt = {pattern_base[0], pattern_base[LED_COUNT-1:1]};
        default: begin
          counter_nxt = counter_inc;
          pattern_nxt = counter_inc;
        end
      endcase
      countdown_nxt = mode_rate;
    end
    countdown_nxt = countdown_nxt - CFG_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pattern_r   <= START_UP;
      mode_r      <= MODE_ROTATE_UP;
      countdown_r <= '0;
      counter_r   <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (step) begin
        pattern_r   <= pattern_nxt;
        mode_r      <= mode_nxt;
        countdown_r <= countdown_nxt;
        counter_r   <= counter_nxt;
      end
    end
  end

  // state only moves when a word is taken, so it doubles as the output word
  assign pattern_ext     = {{LED_OUT_W{1'b0}}, pattern_r};
  assign out_valid       = out_valid_r;
  assign out_led_pattern = pattern_ext[LED_OUT_W-1:0];
  assign out_active_mode = mode_r;

endmodule

`default_nettype wire
